[design/pdfb_pkg.sv]
// ----------------------------------------------------------------------------
// Paged display frame buffer package
// Geometry constants, the action codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pdfb_pkg;

  localparam int DISPLAY_WIDTH = 128;
  localparam int PAGE_COUNT    = 8;
  localparam int STORE_SIZE    = DISPLAY_WIDTH * PAGE_COUNT;

  localparam int ADDR_W    = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int CUR_COL_W = (DISPLAY_WIDTH > 1) ? $clog2(DISPLAY_WIDTH) : 1;
  localparam int CUR_PG_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  typedef enum logic [2:0] {
    ACT_WR_BYTE   = 3'd0,
    ACT_RD_BYTE   = 3'd1,
    ACT_WR_PIXEL  = 3'd2,
    ACT_RD_PIXEL  = 3'd3,
    ACT_SET_CUR   = 3'd4,
    ACT_CUR_WRITE = 3'd5,
    ACT_CLEAR     = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming beat and start the store read
    logic execute;   // perform the action and load the result register
    logic sweep;     // zero one store entry and advance the sweep address
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // the result register can take a new result
    logic is_clear;    // the latched action is a clear
    logic sweep_last;  // the sweep is at the last store entry
  } dp_sts_t;

  // Store address of a byte at a column and page that are in range.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] col,
                                                  input logic [ADDR_W-1:0] pg);
    cell_addr = pg * ADDR_W'(DISPLAY_WIDTH) + col;
  endfunction

endpackage

[design/pdfb_ctrl.sv]
// ----------------------------------------------------------------------------
// Paged display frame buffer controller
// Sequences the sweep, the accept of a beat and the execute step.
// ----------------------------------------------------------------------------
module pdfb_ctrl
  import pdfb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The action commits only once its result has somewhere to go.
        if (sts_i.out_free) begin
          cmd_o.execute = 1'b1;
          state_d       = sts_i.is_clear ? ST_SWEEP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
  end

endmodule

[design/pdfb_dpath.sv]
// ----------------------------------------------------------------------------
// Paged display frame buffer datapath
// Frame store, cursor, latched beat, sweep address and result register.
// ----------------------------------------------------------------------------
module pdfb_dpath
  import pdfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] action_i,
  input  logic [6:0] column_i,
  input  logic [2:0] page_i,
  input  logic [5:0] pixel_row_i,
  input  logic [7:0] write_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       pixel_value_o,
  output logic       range_error_o
);

  logic [7:0] mem_q [STORE_SIZE];
  logic [7:0] rdata_q;

  logic [2:0] act_q;
  logic [6:0] col_q;
  logic [2:0] pg_q;
  logic [5:0] row_q;
  logic [7:0] wdata_q;

  logic [CUR_COL_W-1:0] cur_col_q, cur_col_d;
  logic [CUR_PG_W-1:0]  cur_pg_q, cur_pg_d;
  logic [ADDR_W-1:0]    sweep_q, sweep_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] rd_q, rd_d;
  logic       px_q, px_d;
  logic       err_q, err_d;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              wr_en;
  logic              col_ok, pg_ok, rpg_ok, cur_ok;
  logic [7:0]        mask;
  logic [2:0]        in_pg;

  // Pixel actions address the page that holds the pixel row.
  always_comb begin
    in_pg = page_i;
    if (action_i == ACT_WR_PIXEL || action_i == ACT_RD_PIXEL) begin
      in_pg = pixel_row_i[5:3];
    end
    rd_addr = cell_addr(ADDR_W'(column_i), ADDR_W'(in_pg));
  end

  assign col_ok = 9'(col_q) < 9'(DISPLAY_WIDTH);
  assign pg_ok  = 6'(pg_q) < 6'(PAGE_COUNT);
  assign rpg_ok = 6'(row_q[5:3]) < 6'(PAGE_COUNT);
  assign cur_ok = (9'(cur_col_q) < 9'(DISPLAY_WIDTH)) && (6'(cur_pg_q) < 6'(PAGE_COUNT));
  assign mask   = 8'd1 << row_q[2:0];

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = sweep_q;
    wr_data     = '0;
    cur_col_d   = cur_col_q;
    cur_pg_d    = cur_pg_q;
    sweep_d     = sweep_q;
    rd_d        = '0;
    px_d        = 1'b0;
    err_d       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.sweep) begin
      wr_en   = 1'b1;
      sweep_d = (sweep_q == ADDR_W'(STORE_SIZE - 1)) ? '0 : sweep_q + 1'b1;
    end

    if (cmd_i.execute) begin
      out_valid_d = 1'b1;
      unique case (act_q)
        ACT_WR_BYTE: begin
          err_d   = !(col_ok && pg_ok);
          wr_en   = col_ok && pg_ok;
          wr_addr = cell_addr(ADDR_W'(col_q), ADDR_W'(pg_q));
          wr_data = wdata_q;
        end
        ACT_RD_BYTE: begin
          err_d = !(col_ok && pg_ok);
          rd_d  = (col_ok && pg_ok) ? rdata_q : '0;
        end
        ACT_WR_PIXEL: begin
          err_d   = !(col_ok && rpg_ok);
          wr_en   = col_ok && rpg_ok;
          wr_addr = cell_addr(ADDR_W'(col_q), ADDR_W'(row_q[5:3]));
          wr_data = (rdata_q & ~mask) | ((wdata_q != 8'd0) ? mask : 8'd0);
        end
        ACT_RD_PIXEL: begin
          err_d = !(col_ok && rpg_ok);
          px_d  = col_ok && rpg_ok && ((rdata_q & mask) != 8'd0);
        end
        ACT_SET_CUR: begin
          err_d = !(col_ok && pg_ok);
          if (col_ok && pg_ok) begin
            cur_col_d = CUR_COL_W'(col_q);
            cur_pg_d  = CUR_PG_W'(pg_q);
          end
        end
        ACT_CUR_WRITE: begin
          wr_en   = cur_ok;
          wr_addr = cell_addr(ADDR_W'(cur_col_q), ADDR_W'(cur_pg_q));
          wr_data = wdata_q;
          if (cur_col_q == CUR_COL_W'(DISPLAY_WIDTH - 1)) begin
            cur_col_d = '0;
            cur_pg_d  = (cur_pg_q == CUR_PG_W'(PAGE_COUNT - 1)) ? '0 : cur_pg_q + 1'b1;
          end else begin
            cur_col_d = cur_col_q + 1'b1;
          end
        end
        default: begin
          // A clear is carried out by the sweep that follows; the unused
          // code has no effect.
        end
      endcase
    end
  end

  // Single-port store: reads start on accept, writes happen on execute or
  // sweep, and the controller never asks for both in one cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.capture) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_i;
      col_q   <= column_i;
      pg_q    <= page_i;
      row_q   <= pixel_row_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.execute) begin
      rd_q  <= rd_d;
      px_q  <= px_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_pg_q    <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_col_q   <= cur_col_d;
      cur_pg_q    <= cur_pg_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.is_clear   = act_q == ACT_CLEAR;
  assign sts_o.sweep_last = sweep_q == ADDR_W'(STORE_SIZE - 1);

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_q;
  assign pixel_value_o = px_q;
  assign range_error_o = err_q;

endmodule

[design/paged_display_frame_buffer.sv]
// ----------------------------------------------------------------------------
// Paged display frame buffer
// Monochrome frame store of pages of eight vertical pixels per byte, with
// byte, pixel, cursor and clear actions and one result beat per action.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                  Payload
//   input     in          in_valid_i / in_stall_o    action, column, page,
//                                                    pixel_row, write_data
//   output    out         out_valid_o / out_stall_i  read_data, pixel_value,
//                                                    range_error
//
// An action runs as an accept step and an execute step: the beat is accepted
// and the store read is started in the accept step, and the action executes
// and its result is registered in the execute step, which a stall on the
// output can hold. The single store port sets this split, since a pixel
// write reads the byte and writes it back. A clear adds a sweep of the whole
// store, one store entry per cycle, during which no beat is accepted. After
// reset the same sweep zeroes all 1024 store entries before the first beat
// is taken; the cursor is reset to column zero of page zero at once. While
// a result waits on out_stall_i, the next beat is still accepted and its
// action is held in the execute step until the result register frees.
module paged_display_frame_buffer
  import pdfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [6:0] column_i,
  input  logic [2:0] page_i,
  input  logic [5:0] pixel_row_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       pixel_value_o,
  output logic       range_error_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns sequencing; the datapath owns every stored value.
  pdfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdfb_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .column_i      (column_i),
    .page_i        (page_i),
    .pixel_row_i   (pixel_row_i),
    .write_data_i  (write_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .pixel_value_o (pixel_value_o),
    .range_error_o (range_error_o)
  );

  // Only one action is in flight: an accepted beat closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an action is in flight");

  // A rejected action returns no data.
  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (read_data_o == 8'd0 && !pixel_value_o))
    else $error("range error with nonzero read result");

  // A byte read and a pixel read never report together.
  a_one_read_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(read_data_o != 8'd0 && pixel_value_o))
    else $error("byte and pixel result both nonzero");

endmodule

[tb/paged_display_frame_buffer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged display frame buffer regression
// Drives byte, pixel, cursor, clear and unused actions into the frame buffer.
// Every result beat is checked against a local image of the frame store and
// the cursor, or a pinned row's typed result. A short directed table comes
// first, then random traffic at a few hot cells. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module paged_display_frame_buffer_test;
  import pdfb_pkg::*;

  // Code 7 has no action behind it and must leave everything untouched.
  localparam logic [2:0] ACT_NONE = 3'd7;

  localparam int RANDOM_BEATS = 900;
  // The last beats of the run go through with no idling on either side.
  localparam int QUIET_TAIL   = 100;
  // A clear sweeps 1024 entries with the input closed. The receiver can add
  // an idle burst and the sender a gap on top of that. This limit leaves a
  // wide margin over the sum.
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] column;
    logic [2:0] page;
    logic [5:0] pixel_row;
    logic [7:0] write_data;
  } beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_value;
    logic       range_error;
  } frame_result_t;

  // One directed beat. When pinned is set, the typed result replaces the
  // predicted one.
  typedef struct packed {
    beat_t         cmd;
    logic          pinned;
    frame_result_t want;
  } stim_row_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [2:0] action_i     = ACT_NONE;
  logic [6:0] column_i     = '0;
  logic [2:0] page_i       = '0;
  logic [5:0] pixel_row_i  = '0;
  logic [7:0] write_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] read_data_o;
  logic       pixel_value_o;
  logic       range_error_o;

  // These travel with the beat on the input port. The accept monitor reads
  // them when the beat is taken.
  logic          row_pinned = 1'b0;
  frame_result_t row_want   = '0;

  // Local image of the block: the frame store, the cursor, and the results
  // still owed on the output port, oldest first.
  logic [7:0]           frame_store [PAGE_COUNT][DISPLAY_WIDTH];
  logic [CUR_COL_W-1:0] cursor_col;
  logic [CUR_PG_W-1:0]  cursor_pg;
  frame_result_t        awaited_results [$];

  int unsigned beats_taken = 0;
  int unsigned idle_cycles = 0;
  int unsigned fault_count = 0;
  logic        quiet_tail  = 1'b0;

  paged_display_frame_buffer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .column_i     (column_i),
    .page_i       (page_i),
    .pixel_row_i  (pixel_row_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .pixel_value_o(pixel_value_o),
    .range_error_o(range_error_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void wipe_frame_store();
    for (int p = 0; p < PAGE_COUNT; p++) begin
      for (int c = 0; c < DISPLAY_WIDTH; c++) begin
        frame_store[p][c] = 8'h00;
      end
    end
  endfunction

  function automatic bit on_panel(input int col, input int pg);
    return col < DISPLAY_WIDTH && pg < PAGE_COUNT;
  endfunction

  // Apply one action to the local image and return the result beat it owes.
  // A pixel row selects page row/8 and bit row%8 of that byte.
  function automatic frame_result_t apply_frame_action(input beat_t b);
    frame_result_t res;
    logic [7:0]    bit_mask;
    int            row_pg;
    res      = '0;
    row_pg   = int'(b.pixel_row) / 8;
    bit_mask = 8'h01 << b.pixel_row[2:0];
    case (b.action)
      ACT_WR_BYTE: begin
        if (on_panel(b.column, b.page)) frame_store[b.page][b.column] = b.write_data;
        else res.range_error = 1'b1;
      end
      ACT_RD_BYTE: begin
        if (on_panel(b.column, b.page)) res.read_data = frame_store[b.page][b.column];
        else res.range_error = 1'b1;
      end
      ACT_WR_PIXEL: begin
        if (on_panel(b.column, row_pg)) begin
          // Any nonzero data sets the pixel. Zero data clears it.
          if (b.write_data != 8'h00) frame_store[row_pg][b.column] |= bit_mask;
          else frame_store[row_pg][b.column] &= ~bit_mask;
        end else begin
          res.range_error = 1'b1;
        end
      end
      ACT_RD_PIXEL: begin
        if (on_panel(b.column, row_pg)) begin
          res.pixel_value = |(frame_store[row_pg][b.column] & bit_mask);
        end else begin
          res.range_error = 1'b1;
        end
      end
      ACT_SET_CUR: begin
        if (on_panel(b.column, b.page)) begin
          cursor_col = b.column;
          cursor_pg  = b.page;
        end else begin
          res.range_error = 1'b1;
        end
      end
      ACT_CUR_WRITE: begin
        // The cursor is always in range, so this action never flags an error.
        // It walks along the columns, then down the pages, then back to the top.
        if (on_panel(cursor_col, cursor_pg)) frame_store[cursor_pg][cursor_col] = b.write_data;
        if (int'(cursor_col) + 1 >= DISPLAY_WIDTH) begin
          cursor_col = '0;
          cursor_pg  = (int'(cursor_pg) + 1 >= PAGE_COUNT) ? '0 : cursor_pg + 1'b1;
        end else begin
          cursor_col = cursor_col + 1'b1;
        end
      end
      ACT_CLEAR: wipe_frame_store();  // the cursor keeps its place
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t mk_row(input logic [2:0] act, input int col, input int pg,
                                       input int prow, input int data, input bit pinned,
                                       input int rd, input bit px);
    stim_row_t r;
    r.cmd              = {act, 7'(col), 3'(pg), 6'(prow), 8'(data)};
    r.pinned           = pinned;
    r.want.read_data   = 8'(rd);
    r.want.pixel_value = px;
    r.want.range_error = 1'b0;
    return r;
  endfunction

  // Random traffic mostly hits a handful of columns at both panel edges.
  // That way reads tend to find bytes that earlier beats wrote.
  function automatic logic [6:0] pick_column();
    int sel;
    sel = $urandom_range(0, 7);
    if ($urandom_range(0, 2) == 0) return 7'($urandom_range(0, 127));
    return (sel < 4) ? 7'(sel) : 7'(120 + sel);
  endfunction

  function automatic logic [2:0] pick_page();
    if ($urandom_range(0, 1) == 0) return 3'($urandom_range(0, 7));
    return ($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // Present one beat at a falling edge and hold it until it is taken. A random
  // gap may come first. Valid is never dropped and raised in the same step.
  task automatic send_beat(input beat_t b, input logic pinned, input frame_result_t want);
    int unsigned target;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    target = beats_taken + 1;
    in_valid_i <= 1'b1;
    {action_i, column_i, page_i, pixel_row_i, write_data_i} <= b;
    row_pinned <= pinned;
    row_want   <= want;
    do @(negedge clk_i); while (beats_taken != target);
  endtask

  // Input side: each beat taken updates the image and queues its expected
  // result. The sampled stall is the value from before this edge.
  always @(posedge clk_i) begin : beat_accept
    beat_t         b;
    frame_result_t predicted;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      b         = {action_i, column_i, page_i, pixel_row_i, write_data_i};
      predicted = apply_frame_action(b);
      awaited_results.push_back(row_pinned ? row_want : predicted);
      beats_taken++;
    end
  end

  // Output side: every result beat must match the oldest expectation.
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result beat, expected none, actual 0x%0h/%0b/%0b",
                 $time, read_data_o, pixel_value_o, range_error_o);
      end else begin
        want = awaited_results.pop_front();
        check_field("read_data", want.read_data, read_data_o);
        check_field("pixel_value", want.pixel_value, pixel_value_o);
        check_field("range_error", want.range_error, range_error_o);
      end
    end
  end

  // Watchdog: stop the run if no beat moves on either port for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("paged_display_frame_buffer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver raises random stall bursts, none in the quiet tail.
  initial begin : receiver_stalls
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   directed_rows [$];
    beat_t       b;
    int unsigned sent;
    int unsigned run_len;
    int          pick;

    wipe_frame_store();
    cursor_col = '0;
    cursor_pg  = '0;

    // After reset the store reads as zero everywhere, corners included.
    directed_rows.push_back(mk_row(ACT_RD_BYTE,     0, 0,  0, 8'h00, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_BYTE,   127, 7, 63, 8'hFF, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_PIXEL,  127, 7, 63, 8'hFF, 1, 8'h00, 0));
    // Full byte in the last cell, then clear its pixel at row 63 with zero data.
    directed_rows.push_back(mk_row(ACT_WR_BYTE,   127, 7, 63, 8'hFF, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_BYTE,   127, 7,  0, 8'h00, 1, 8'hFF, 0));
    directed_rows.push_back(mk_row(ACT_WR_PIXEL,  127, 0, 63, 8'h00, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_BYTE,   127, 7,  0, 8'h00, 1, 8'h7F, 0));
    directed_rows.push_back(mk_row(ACT_RD_PIXEL,  127, 0, 62, 8'h00, 1, 8'h00, 1));
    // Any nonzero data sets a pixel, even with bit zero of the data low.
    directed_rows.push_back(mk_row(ACT_WR_PIXEL,    0, 7,  0, 8'h80, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_PIXEL,    0, 7,  0, 8'h00, 1, 8'h00, 1));
    directed_rows.push_back(mk_row(ACT_RD_BYTE,     0, 0, 63, 8'h00, 1, 8'h01, 0));
    // Cursor at the very last cell: the second write wraps to the top left.
    directed_rows.push_back(mk_row(ACT_SET_CUR,   127, 7, 63, 8'hFF, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_CUR_WRITE,   0, 0,  0, 8'hA5, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_CUR_WRITE, 127, 7, 63, 8'h5A, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_BYTE,   127, 7,  0, 8'h00, 0, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_BYTE,     0, 0,  0, 8'h00, 0, 8'h00, 0));
    // End of a middle page: the cursor moves on to column zero of the next page.
    directed_rows.push_back(mk_row(ACT_SET_CUR,   127, 3,  0, 8'h00, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_CUR_WRITE,  64, 5, 31, 8'h3C, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_CUR_WRITE,   1, 2, 17, 8'hC3, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_BYTE,     0, 4,  0, 8'h00, 0, 8'h00, 0));
    // The unused code with every field at its maximum does nothing.
    directed_rows.push_back(mk_row(ACT_NONE,      127, 7, 63, 8'hFF, 1, 8'h00, 0));
    // A clear wipes everything, and the next reads see zero again.
    directed_rows.push_back(mk_row(ACT_CLEAR,     127, 7, 63, 8'hFF, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_BYTE,   127, 7,  0, 8'h00, 1, 8'h00, 0));
    directed_rows.push_back(mk_row(ACT_RD_PIXEL,    0, 0,  0, 8'h00, 1, 8'h00, 0));
    // The cursor came through the clear: this write lands at column 1, page 4.
    directed_rows.push_back(mk_row(ACT_CUR_WRITE,   0, 0,  0, 8'h96, 1, 8'h00, 0));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      send_beat(directed_rows[k].cmd, directed_rows[k].pinned, directed_rows[k].want);

    // Random part. All fields carry random content on every beat, including the
    // fields that the action ignores.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      quiet_tail = (sent >= RANDOM_BEATS - QUIET_TAIL);
      pick = $urandom_range(0, 99);
      b.column     = pick_column();
      b.page       = pick_page();
      b.pixel_row  = {pick_page(), 3'($urandom_range(0, 7))};
      b.write_data = 8'($urandom);
      if (pick < 6) begin
        // A cursor run starts near the end of a page, so it often wraps.
        b.action = ACT_SET_CUR;
        b.column = 7'($urandom_range(120, 127));
        send_beat(b, 1'b0, '0);
        run_len = $urandom_range(2, 9);
        repeat (run_len) begin
          b.action     = ACT_CUR_WRITE;
          b.write_data = 8'($urandom);
          send_beat(b, 1'b0, '0);
        end
        sent += run_len + 1;
      end else begin
        if (pick < 24)      b.action = ACT_WR_BYTE;
        else if (pick < 46) b.action = ACT_RD_BYTE;
        else if (pick < 60) begin
          b.action = ACT_WR_PIXEL;
          if ($urandom_range(0, 1) == 0) b.write_data = 8'h00;
        end
        else if (pick < 78) b.action = ACT_RD_PIXEL;
        else if (pick < 84) b.action = ACT_SET_CUR;
        else if (pick < 96) b.action = ACT_CUR_WRITE;
        else if (pick < 98) b.action = ACT_NONE;
        else                b.action = ACT_CLEAR;
        send_beat(b, 1'b0, '0);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("paged_display_frame_buffer regression: pass");
    end else begin
      $display("paged_display_frame_buffer regression: fail");
    end
    $finish;
  end

endmodule
